// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/rhf_pkg.sv
package rhf_pkg;

    localparam int unsigned MAX_READ_LENGTH = 65535;
    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_LIMIT =
        (MAX_READ_LENGTH < 65535) ? CNT_W'(MAX_READ_LENGTH) : CNT_W'(65535);

    localparam int unsigned BASE_W = 8;
    localparam int unsigned THR_W = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned VERDICT_W = 2;

    localparam logic CFG_LENGTH_CUTOFF = 1'b0;
    localparam logic CFG_RUN_THRESHOLD = 1'b1;

    localparam logic [CNT_W-1:0] LENGTH_CUTOFF_RESET = 16'd50;
    localparam logic [THR_W-1:0] RUN_THRESHOLD_RESET = 8'd10;

    localparam logic [VERDICT_W-1:0] VERDICT_GOOD = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_SHORT = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_ARTIFACT = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

    // classified base: continues the current run or opens a new one
    typedef struct packed {
        logic cont;
        logic last;
    } t_rhf_op;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
        return (a >= CNT_LIMIT) ? CNT_LIMIT : a + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, CNT_LIMIT}) ? CNT_LIMIT : s[CNT_W-1:0];
    endfunction

endpackage

// File: design/rhf_front.sv
module rhf_front import rhf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BASE_W-1:0] i_base,
    input  logic              i_last,
    input  logic              i_queue_full,
    output logic              o_push,
    output t_rhf_op           o_op
);

    logic [BASE_W-1:0] r_prev_base;
    logic              r_in_read;

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_op.cont = r_in_read && (i_base == r_prev_base);
        o_op.last = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_read   <= 1'b0;
            r_prev_base <= '0;
        end else if (o_push) begin
            r_in_read   <= !i_last;
            r_prev_base <= i_base;
        end
    end

endmodule

// File: design/rhf_queue.sv
module rhf_queue import rhf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_rhf_op i_op,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_rhf_op o_op
);

    t_rhf_op                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

// File: design/rhf_back.sv
module rhf_back import rhf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_op_valid,
    input  t_rhf_op              i_op,
    output logic                 o_pop,
    input  logic [CNT_W-1:0]     i_length_cutoff,
    input  logic [THR_W-1:0]     i_run_threshold,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [VERDICT_W-1:0] o_verdict,
    output logic [CNT_W-1:0]     o_read_length,
    output logic [CNT_W-1:0]     o_repeat_bases
);

    logic [CNT_W-1:0]     r_run_len;
    logic [CNT_W-1:0]     r_repeat_sum;
    logic [CNT_W-1:0]     r_length_count;
    logic                 r_out_valid;
    logic [VERDICT_W-1:0] r_verdict;
    logic [CNT_W-1:0]     r_out_length;
    logic [CNT_W-1:0]     r_out_repeat;

    logic [CNT_W-1:0]     n_run_len;
    logic [CNT_W-1:0]     n_repeat_sum;
    logic [CNT_W-1:0]     n_length_count;
    logic [CNT_W-1:0]     n_final_sum;
    logic [VERDICT_W-1:0] n_verdict;
    logic [CNT_W-1:0]     w_thr;

    assign w_thr = {{(CNT_W-THR_W){1'b0}}, i_run_threshold};
    assign o_pop = i_op_valid && (!i_op.last || !r_out_valid || i_ready);

    always_comb begin
        // close the previous run when this base opens a new one
        if (!i_op.cont && (r_run_len > w_thr)) begin
            n_repeat_sum = sat_add(r_repeat_sum, r_run_len);
        end else begin
            n_repeat_sum = r_repeat_sum;
        end
        n_run_len      = i_op.cont ? sat_inc(r_run_len) : CNT_W'(1);
        n_length_count = sat_inc(r_length_count);
        // final run closes at end of read
        n_final_sum = (n_run_len > w_thr) ? sat_add(n_repeat_sum, n_run_len)
                                          : n_repeat_sum;
        if (n_length_count < i_length_cutoff) begin
            n_verdict = VERDICT_SHORT;
        end else if ({n_final_sum, 1'b0} > {1'b0, n_length_count}) begin
            n_verdict = VERDICT_ARTIFACT;
        end else begin
            n_verdict = VERDICT_GOOD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_len      <= '0;
            r_repeat_sum   <= '0;
            r_length_count <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_op.last) begin
                    r_run_len      <= '0;
                    r_repeat_sum   <= '0;
                    r_length_count <= '0;
                end else begin
                    r_run_len      <= n_run_len;
                    r_repeat_sum   <= n_repeat_sum;
                    r_length_count <= n_length_count;
                end
            end
            if (o_pop && i_op.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_op.last) begin
            r_verdict    <= n_verdict;
            r_out_length <= n_length_count;
            r_out_repeat <= n_final_sum;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_read_length  = r_out_length;
    assign o_repeat_bases = r_out_repeat;

endmodule

// File: design/read_homopolymer_filter.sv
// output: the last base of a read is pushed into the queue when accepted, and its pop
//   updates the output reg; the pop waits while an earlier verdict is stalled
// throughput: one base per cycle while the queue is not full; the back counters update on each popped base
// reset: synchronous active low; clears run state, queue and output valid,
//   length_cutoff returns to 50 and run_threshold to 10
module read_homopolymer_filter import rhf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [BASE_W-1:0]     i_base,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [VERDICT_W-1:0]  o_verdict,
    output logic [CNT_W-1:0]      o_read_length,
    output logic [CNT_W-1:0]      o_repeat_bases,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CNT_W-1:0] r_length_cutoff;
    logic [THR_W-1:0] r_run_threshold;

    logic    w_push;
    t_rhf_op w_push_op;
    logic    w_full;
    logic    w_pop;
    logic    w_op_valid;
    t_rhf_op w_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_cutoff <= LENGTH_CUTOFF_RESET;
            r_run_threshold <= RUN_THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LENGTH_CUTOFF: r_length_cutoff <= i_cfg_data[CNT_W-1:0];
                CFG_RUN_THRESHOLD: r_run_threshold <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    rhf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_base       (i_base),
        .i_last       (i_last),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_op         (w_push_op)
    );

    rhf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_op_valid),
        .o_op    (w_op)
    );

    rhf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_valid      (w_op_valid),
        .i_op            (w_op),
        .o_pop           (w_pop),
        .i_length_cutoff (r_length_cutoff),
        .i_run_threshold (r_run_threshold),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_verdict       (o_verdict),
        .o_read_length   (o_read_length),
        .o_repeat_bases  (o_repeat_bases)
    );

endmodule

// File: design/rhf_checker.sv
`include "assert_macros.svh"

module rhf_checker import rhf_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [VERDICT_W-1:0] o_verdict,
    input logic [CNT_W-1:0]     o_read_length,
    input logic [CNT_W-1:0]     o_repeat_bases
);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_verdict) && $stable(o_read_length) && $stable(o_repeat_bases))

    // a read has at least one base
    `ASSERT_IMPLIES(a_len_nonzero, i_clk, i_rst_n, o_valid, o_read_length != '0)

    // repeat bases are a subset of the read
    `ASSERT_IMPLIES(a_rep_le_len, i_clk, i_rst_n, o_valid, o_repeat_bases <= o_read_length)

    // artifact exactly when repeats dominate, unless short
    `ASSERT_IMPLIES(a_artifact, i_clk, i_rst_n, o_valid && (o_verdict != VERDICT_SHORT), (o_verdict == VERDICT_ARTIFACT) == ({o_repeat_bases, 1'b0} > {1'b0, o_read_length}))

endmodule

bind read_homopolymer_filter rhf_checker u_rhf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_verdict      (o_verdict),
    .o_read_length  (o_read_length),
    .o_repeat_bases (o_repeat_bases)
);

// File: sim/read_homopolymer_filter_tb.sv
`timescale 1ns / 1ps

module read_homopolymer_filter_tb;
    import rhf_pkg::*;

    typedef struct {
        logic [BASE_W-1:0] base;
        logic              last;
    } base_req_t;

    typedef struct {
        logic [VERDICT_W-1:0] verdict;
        logic [CNT_W-1:0]     read_length;
        logic [CNT_W-1:0]     repeat_bases;
    } read_verdict_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [BASE_W-1:0]     i_base = '0;
    logic                  i_last = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [VERDICT_W-1:0]  o_verdict;
    logic [CNT_W-1:0]      o_read_length;
    logic [CNT_W-1:0]      o_repeat_bases;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_index = CFG_LENGTH_CUTOFF;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    base_req_t     pending_bases[$];
    read_verdict_t expected_verdicts[$];

    // predicted block state and register copies
    logic [BASE_W-1:0] run_byte = '0;
    logic [CNT_W-1:0]  run_len = '0;
    logic [CNT_W-1:0]  long_run_sum = '0;
    logic [CNT_W-1:0]  base_count = '0;
    logic [CNT_W-1:0]  cutoff_reg = LENGTH_CUTOFF_RESET;
    logic [THR_W-1:0]  thresh_reg = RUN_THRESHOLD_RESET;

    logic base_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   mismatches = 0;

    logic [BASE_W-1:0] nucleotides [5] = '{"A", "C", "G", "T", "N"};

    read_homopolymer_filter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_base         (i_base),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_verdict      (o_verdict),
        .o_read_length  (o_read_length),
        .o_repeat_bases (o_repeat_bases),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] clip_add(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = a + b;
        clip_add = (s > CNT_LIMIT) ? CNT_LIMIT : s[CNT_W-1:0];
    endfunction

    function void track_base(input logic [BASE_W-1:0] b, input logic l);
        read_verdict_t res;
        if (run_len != 0 && b == run_byte) begin
            run_len = clip_add(run_len, CNT_W'(1));
        end else begin
            if (run_len > thresh_reg) begin
                long_run_sum = clip_add(long_run_sum, run_len);
            end
            run_byte = b;
            run_len = CNT_W'(1);
        end
        base_count = clip_add(base_count, CNT_W'(1));
        if (l) begin
            if (run_len > thresh_reg) begin
                long_run_sum = clip_add(long_run_sum, run_len);
            end
            if (base_count < cutoff_reg) begin
                res.verdict = VERDICT_SHORT;
            end else if ({long_run_sum, 1'b0} > {1'b0, base_count}) begin
                res.verdict = VERDICT_ARTIFACT;
            end else begin
                res.verdict = VERDICT_GOOD;
            end
            res.read_length = base_count;
            res.repeat_bases = long_run_sum;
            expected_verdicts.push_back(res);
            run_byte = '0;
            run_len = '0;
            long_run_sum = '0;
            base_count = '0;
        end
    endfunction

    // track accepted bases and predict verdicts
    always @(posedge i_clk) begin
        base_taken <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            track_base(i_base, i_last);
        end
    end

    always @(negedge i_clk) begin : driver
        base_req_t req;
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (i_rst_n && (!i_valid || base_taken)) begin
            if (pending_bases.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                req = pending_bases.pop_front();
                i_valid <= 1'b1;
                i_base <= req.base;
                i_last <= req.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        read_verdict_t exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected verdict %0d length %0d repeats %0d",
                             o_verdict, o_read_length, o_repeat_bases);
                end
            end else begin
                exp_res = expected_verdicts.pop_front();
                if (o_verdict !== exp_res.verdict || o_read_length !== exp_res.read_length ||
                    o_repeat_bases !== exp_res.repeat_bases) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("verdict mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 exp_res.verdict, exp_res.read_length, exp_res.repeat_bases,
                                 o_verdict, o_read_length, o_repeat_bases);
                    end
                end
            end
        end
    end

    task automatic push_run(input logic [BASE_W-1:0] b, input int n, input logic l);
        base_req_t req;
        for (int k = 0; k < n; k++) begin
            req.base = b;
            req.last = l && (k == n - 1);
            pending_bases.push_back(req);
        end
    endtask

    task automatic set_config(input logic [CNT_W-1:0] cutoff,
                              input logic [CFG_DATA_W-1:0] thresh_word);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LENGTH_CUTOFF;
        i_cfg_data <= cutoff;
        do @(posedge i_clk); while (!o_cfg_ready);
        cutoff_reg = cutoff;
        @(negedge i_clk);
        i_cfg_index <= CFG_RUN_THRESHOLD;
        i_cfg_data <= thresh_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        thresh_reg = thresh_word[THR_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_bases.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // reads built from runs, mostly short runs with some near the threshold, plus some noise reads of arbitrary bytes
    task automatic queue_random_reads(input int min_items, input int min_reads);
        int items;
        int reads;
        int n_runs;
        int run_n;
        logic [BASE_W-1:0] b;
        items = 0;
        reads = 0;
        while (items < min_items || reads < min_reads) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise read of arbitrary bytes
                run_n = $urandom_range(1, 12);
                for (int k = 0; k < run_n; k++) begin
                    push_run(8'($urandom_range(0, 255)), 1, k == run_n - 1);
                end
                items += run_n;
            end else begin
                n_runs = $urandom_range(1, 6);
                for (int r = 0; r < n_runs; r++) begin
                    if ($urandom_range(0, 4) != 0) begin
                        b = nucleotides[$urandom_range(0, 4)];
                    end else begin
                        b = 8'($urandom_range(0, 255));
                    end
                    if ($urandom_range(0, 9) < 7) begin
                        run_n = $urandom_range(1, 3);
                    end else begin
                        run_n = $urandom_range((thresh_reg > 1) ? thresh_reg - 1 : 1,
                                               thresh_reg + 2);
                    end
                    push_run(b, run_n, r == n_runs - 1);
                    items += run_n;
                end
            end
            reads++;
        end
    endtask

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        send_idle_pct = 22;
        recv_idle_pct = 55;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed reads
        set_config(16'd3, 16'd2);
        push_run("A", 5, 1'b1);
        push_run(8'hFF, 1, 1'b1);
        push_run(8'h00, 2, 1'b0);
        push_run(8'hFF, 1, 1'b0);
        push_run(8'h55, 1, 1'b0);
        push_run(8'hAA, 1, 1'b1);
        push_run("A", 3, 1'b0);
        push_run("C", 3, 1'b1);
        push_run("C", 1, 1'b0);
        push_run("A", 2, 1'b0);
        push_run("C", 1, 1'b0);
        push_run("A", 1, 1'b1);
        drain();
        // threshold zero, upper data bits ignored
        set_config(16'd0, 16'hAB00);
        push_run("G", 1, 1'b0);
        push_run("T", 1, 1'b1);
        drain();

        set_config(16'($urandom_range(0, 40)), 16'($urandom_range(1, 8)));
        queue_random_reads(130, 14);
        drain();
        set_config(16'd0, 16'd1);
        queue_random_reads(130, 14);
        drain();
        set_config(16'hFFFF, 16'($urandom_range(1, 8)));
        queue_random_reads(130, 14);
        drain();

        send_idle_pct = 55;
        recv_idle_pct = 22;
        set_config(16'($urandom_range(0, 40)), {8'($urandom), 8'd0});
        queue_random_reads(130, 14);
        drain();
        set_config(16'($urandom_range(0, 40)), 16'd255);
        queue_random_reads(200, 1);
        drain();
        set_config(16'($urandom_range(0, 40)), 16'($urandom_range(1, 8)));
        queue_random_reads(130, 14);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(16'($urandom_range(0, 40)), {8'($urandom), 8'($urandom_range(1, 8))});
        queue_random_reads(130, 14);
        drain();
        set_config(16'($urandom_range(0, 40)), 16'($urandom_range(1, 8)));
        queue_random_reads(130, 14);
        drain();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: read_homopolymer_filter.f
+incdir+design
design/rhf_pkg.sv
design/rhf_front.sv
design/rhf_queue.sv
design/rhf_back.sv
design/read_homopolymer_filter.sv
design/rhf_checker.sv
sim/read_homopolymer_filter_tb.sv
